FILE: hw/rtl/pbv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbv_pkg
// Shared types, constants and the CRC-32 byte update for the block validator.
// ----------------------------------------------------------------------------
package pbv_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DIFF_W    = 6;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MSG_BYTES = 20;

    localparam logic [DIFF_W-1:0] DIFF_RESET = 6'd16;
    localparam logic [DIFF_W-1:0] DIFF_MAX   = 6'd32;
    localparam logic [WORD_W-1:0] CRC_POLY   = 32'hEDB8_8320;

    // Status codes, in check priority order
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PREV   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HEIGHT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HASH   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIFF   = 3'd4;

    // One block: proposed item or stored head
    typedef struct packed {
        logic [WORD_W-1:0] height;
        logic [WORD_W-1:0] timestamp;
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] prev;
        logic [DIFF_W-1:0] difficulty;
        logic [WORD_W-1:0] nonce;
        logic [WORD_W-1:0] miner;
    } blk_t;

    // Reflected CRC-32 update over one byte, LSB first
    function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/pow_block_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow_block_validator
// Checks proposed blocks against the stored chain head and advances the head.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one proposed block per transaction.
//   Result channel (m_valid/m_ready) returns one transaction per block: the
//   accept flag, a status code, the computed CRC and the head after the check.
//   cfg_wr_en/cfg_wr_data write the difficulty register; write only while idle.
// Timing:
//   A block lands in the input register, then CRC and all checks run
//   combinationally against the head register and the result register is loaded.
//   Throughput: one block per cycle while m_ready accepts each result; the head
//   feedback through the compare and update logic is the loop that sets this.
// Reset: head becomes the all-zero genesis block (difficulty field 16),
//   difficulty register is 16, both pipeline stages are empty.
// Stall: while a result waits on m_ready, one more block is still taken into
//   the input register; after that s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module pow_block_validator (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [pbv_pkg::DIFF_W-1:0]        cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pbv_pkg::WORD_W-1:0]        s_blk_height,
    input  logic [pbv_pkg::WORD_W-1:0]        s_blk_timestamp,
    input  logic [pbv_pkg::WORD_W-1:0]        s_blk_hash,
    input  logic [pbv_pkg::WORD_W-1:0]        s_blk_prev_hash,
    input  logic [pbv_pkg::DIFF_W-1:0]        s_blk_difficulty,
    input  logic [pbv_pkg::WORD_W-1:0]        s_blk_nonce,
    input  logic [pbv_pkg::WORD_W-1:0]        s_blk_miner,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [pbv_pkg::STATUS_W-1:0]      m_status,
    output logic [pbv_pkg::WORD_W-1:0]        m_computed_crc,
    output logic [pbv_pkg::WORD_W-1:0]        m_head_height_out,
    output logic [pbv_pkg::WORD_W-1:0]        m_head_timestamp_out,
    output logic [pbv_pkg::WORD_W-1:0]        m_head_hash_out,
    output logic [pbv_pkg::WORD_W-1:0]        m_head_prev_out,
    output logic [pbv_pkg::DIFF_W-1:0]        m_head_difficulty_out,
    output logic [pbv_pkg::WORD_W-1:0]        m_head_nonce_out,
    output logic [pbv_pkg::WORD_W-1:0]        m_head_miner_out
);

    pbv_pkg::blk_t                      in_reg;
    logic                               in_valid_reg;
    pbv_pkg::blk_t                      head_reg;
    pbv_pkg::blk_t                      head_next;
    logic [pbv_pkg::DIFF_W-1:0]         diff_reg;

    logic                               out_valid_reg;
    logic                               out_acc_reg;
    logic [pbv_pkg::STATUS_W-1:0]       out_status_reg;
    logic [pbv_pkg::WORD_W-1:0]         out_crc_reg;
    pbv_pkg::blk_t                      out_head_reg;

    logic                               advance;
    logic                               load_out;
    logic                               head_we;
    logic [pbv_pkg::WORD_W-1:0]         crc;
    logic [pbv_pkg::DIFF_W-1:0]         diff_sat;
    logic [pbv_pkg::WORD_W:0]           limit;
    logic [pbv_pkg::WORD_W-1:0]         height_m1;
    logic [pbv_pkg::STATUS_W-1:0]       status;

    // Pipeline handshake
    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign load_out = in_valid_reg && advance;

    // Difficulty register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_reg <= pbv_pkg::DIFF_RESET;
        end else if (cfg_wr_en) begin
            diff_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.height     <= s_blk_height;
            in_reg.timestamp  <= s_blk_timestamp;
            in_reg.hash       <= s_blk_hash;
            in_reg.prev       <= s_blk_prev_hash;
            in_reg.difficulty <= s_blk_difficulty;
            in_reg.nonce      <= s_blk_nonce;
            in_reg.miner      <= s_blk_miner;
        end
    end

    // CRC over the registered block
    pbv_crc32 u_crc (
        .blk (in_reg),
        .crc (crc)
    );

    // Checks in priority order
    assign diff_sat  = (diff_reg > pbv_pkg::DIFF_MAX) ? pbv_pkg::DIFF_MAX : diff_reg;
    assign limit     = (pbv_pkg::WORD_W+1)'(1) << (pbv_pkg::DIFF_MAX - diff_sat);
    assign height_m1 = in_reg.height - pbv_pkg::WORD_W'(1);

    always_comb begin
        if (in_reg.prev != head_reg.hash) begin
            status = pbv_pkg::ST_PREV;
        end else if (height_m1 != head_reg.height) begin
            status = pbv_pkg::ST_HEIGHT;
        end else if (crc != in_reg.hash) begin
            status = pbv_pkg::ST_HASH;
        end else if ({1'b0, in_reg.hash} > limit) begin
            status = pbv_pkg::ST_DIFF;
        end else begin
            status = pbv_pkg::ST_OK;
        end
    end

    // Head update
    assign head_we   = load_out && (status == pbv_pkg::ST_OK);
    assign head_next = head_we ? in_reg : head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.height     <= '0;
            head_reg.timestamp  <= '0;
            head_reg.hash       <= '0;
            head_reg.prev       <= '0;
            head_reg.difficulty <= pbv_pkg::DIFF_RESET;
            head_reg.nonce      <= '0;
            head_reg.miner      <= '0;
        end else begin
            head_reg <= head_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_acc_reg    <= (status == pbv_pkg::ST_OK);
            out_status_reg <= status;
            out_crc_reg    <= crc;
            out_head_reg   <= head_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_accepted            = out_acc_reg;
    assign m_status              = out_status_reg;
    assign m_computed_crc        = out_crc_reg;
    assign m_head_height_out     = out_head_reg.height;
    assign m_head_timestamp_out  = out_head_reg.timestamp;
    assign m_head_hash_out       = out_head_reg.hash;
    assign m_head_prev_out       = out_head_reg.prev;
    assign m_head_difficulty_out = out_head_reg.difficulty;
    assign m_head_nonce_out      = out_head_reg.nonce;
    assign m_head_miner_out      = out_head_reg.miner;

    // Checks
    a_acc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_accepted == (m_status == pbv_pkg::ST_OK)))
        else $error("accept flag disagrees with status");

    a_acc_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_head_hash_out == m_computed_crc))
        else $error("accepted head hash differs from computed CRC");

    a_head_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(head_reg)) |-> $past(head_we))
        else $error("head changed without an accepted block");

    a_head_link: assert property (@(posedge aclk) disable iff (!aresetn)
        head_we |=> (head_reg.prev == $past(head_reg.hash)))
        else $error("new head does not extend old head");

endmodule

FILE: hw/rtl/pbv_crc32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbv_crc32
// Combinational CRC-32 over the 20 message bytes of a block, seeded with the
// inverse of the previous hash; flattens to one XOR network.
// ----------------------------------------------------------------------------
module pbv_crc32 (
    input  pbv_pkg::blk_t                   blk,
    output logic [pbv_pkg::WORD_W-1:0]      crc
);

    logic [pbv_pkg::MSG_BYTES*pbv_pkg::BYTE_W-1:0] msg;

    // Little-endian words, height first
    assign msg = {blk.miner, blk.nonce, blk.prev, blk.timestamp, blk.height};

    // Byte-wise update, final inversion
    always_comb begin
        logic [pbv_pkg::WORD_W-1:0] c;
        c = ~blk.prev;
        for (int i = 0; i < pbv_pkg::MSG_BYTES; i++) begin
            c = pbv_pkg::crc32_byte(c, msg[i*pbv_pkg::BYTE_W +: pbv_pkg::BYTE_W]);
        end
        crc = ~c;
    end

endmodule
